### rtl/phle_pkg.sv
// Shared constants, widths and state type for the pulse-height charge estimator.
package phle_pkg;

   localparam int BINS        = 256;
   localparam int COUNT_WIDTH = 8;

   localparam int FIELD_W = 8;                    // charge_index / adc_code field width
   localparam int IDX_W   = $clog2(BINS);
   localparam int ADDR_W  = 2 * IDX_W;            // {charge row, adc column}
   localparam int CNT_W   = COUNT_WIDTH;
   localparam int TOT_W   = IDX_W + CNT_W;        // column total
   localparam int WSUM_W  = 2 * IDX_W + CNT_W;    // sum of index * count
   localparam int ISUM_W  = 2 * IDX_W;            // sum of tied indices
   localparam int TIE_W   = IDX_W + 1;            // number of tied indices
   localparam int FRAC_W  = 8;                    // Q8.8 fraction bits
   localparam int NUM_W   = WSUM_W + FRAC_W;
   localparam int DEN_W   = TOT_W;
   localparam int EST_W   = 16;

   localparam logic KIND_FILL  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic MODE_MEAN = 1'b0;
   localparam logic MODE_PEAK = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_SCAN,
      ST_SCAN_TIE,
      ST_DIV,
      ST_FINISH
   } state_type;

   function automatic logic in_range(input logic [FIELD_W-1:0] v);
      return (32'(v) < BINS);
   endfunction

endpackage

### rtl/phle_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both estimate modes.
module phle_divider
   import phle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;        // dividend shifts out, quotient shifts in
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;        // remainder stays below the divisor
   logic [DEN_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/pulse_height_lut_charge_estimator_core.sv
// Top level: count store, column scan sequencer and result register.
// Fill word: accept, read, write back. Query, mean mode: one store read per column entry,
// then one quotient bit per cycle. Query, mode mode: a second pass over entries 1..BINS-1
// gathers tied peaks before the divide. Empty column, mean mode: the divide is skipped and
// the estimate is zero. One word at a time; a result waits in its register.
// Reset is synchronous: it clears control state and the mode register, then a clearing pass
// writes zero to all 2**(2*IDX_W) entries, during which no word is accepted.
module pulse_height_lut_charge_estimator_core
   import phle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] charge_index, [15:8] adc_code
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] charge_estimate, [16] column_empty, [23:17] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata    // estimate_mode
);

   logic [CNT_W-1:0] store_mem [2**ADDR_W];

   state_type         state_ff, state_in;
   logic              mode_ff;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic              col_ok_ff, col_ok_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              issue_ff, issue_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  rd_data_ff;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [CNT_W-1:0]  best_ff, best_in;
   logic [ISUM_W-1:0] isum_ff, isum_in;
   logic [TIE_W-1:0]  ties_ff, ties_in;
   logic [EST_W-1:0]  est_ff, est_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [EST_W-1:0]  rsp_est_ff;
   logic              rsp_empty_ff;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic [CNT_W-1:0]  cnt;
   logic              last_rd;
   logic              rsp_load;
   logic              div_start;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic              div_done;
   logic [NUM_W-1:0]  div_quo;
   logic              req_acc;

   phle_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // an out-of-range column reads as empty
   assign cnt     = col_ok_ff ? rd_data_ff : '0;
   assign last_rd = rd_vld_ff && (rd_idx_ff == IDX_W'(BINS - 1));

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      col_ok_in  = col_ok_ff;
      scan_in    = scan_ff;
      issue_in   = issue_ff;
      rd_vld_in  = 1'b0;
      rd_idx_in  = rd_idx_ff;
      total_in   = total_ff;
      wsum_in    = wsum_ff;
      best_in    = best_ff;
      isum_in    = isum_ff;
      ties_in    = ties_ff;
      est_in     = est_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      rsp_load   = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = {row_ff, col_ff};
      wr_en      = 1'b0;
      wr_addr    = {row_ff, col_ff};
      wr_data    = rd_data_ff + 1'b1;
      div_start  = 1'b0;
      div_num    = {wsum_ff, {FRAC_W{1'b0}}};
      div_den    = total_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               row_in    = IDX_W'(req_tdata[FIELD_W-1:0]);
               col_in    = IDX_W'(req_tdata[2*FIELD_W-1:FIELD_W]);
               col_ok_in = in_range(req_tdata[2*FIELD_W-1:FIELD_W]);
               if (req_tuser == KIND_QUERY) begin
                  scan_in  = '0;
                  issue_in = 1'b1;
                  total_in = '0;
                  wsum_in  = '0;
                  best_in  = '0;
                  state_in = ST_SCAN;
               end else if (in_range(req_tdata[FIELD_W-1:0]) &&
                            in_range(req_tdata[2*FIELD_W-1:FIELD_W])) begin
                  state_in = ST_FILL_RD;
               end
            end
         end
         ST_FILL_RD: begin
            rd_en    = 1'b1;
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN, ST_SCAN_TIE: begin
            rd_addr = {scan_ff, col_ff};
            if (issue_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff;
               scan_in   = scan_ff + 1'b1;
               if (scan_ff == IDX_W'(BINS - 1)) begin
                  issue_in = 1'b0;
               end
            end
            if (state_ff == ST_SCAN) begin
               if (rd_vld_ff) begin
                  total_in = total_ff + TOT_W'(cnt);
                  wsum_in  = wsum_ff + WSUM_W'(rd_idx_ff) * WSUM_W'(cnt);
                  if ((rd_idx_ff != '0) && (cnt > best_ff)) begin
                     best_in = cnt;
                  end
               end
               if (last_rd) begin
                  if (mode_ff == MODE_PEAK) begin
                     // second pass skips charge index zero
                     scan_in  = IDX_W'(1);
                     issue_in = 1'b1;
                     isum_in  = '0;
                     ties_in  = '0;
                     state_in = ST_SCAN_TIE;
                  end else if (total_in == '0) begin
                     est_in   = '0;
                     state_in = ST_FINISH;
                  end else begin
                     div_start = 1'b1;
                     div_num   = {wsum_in, {FRAC_W{1'b0}}};
                     div_den   = total_in;
                     state_in  = ST_DIV;
                  end
               end
            end else begin
               if (rd_vld_ff && (cnt == best_ff)) begin
                  isum_in = isum_ff + ISUM_W'(rd_idx_ff);
                  ties_in = ties_ff + 1'b1;
               end
               if (last_rd) begin
                  div_start = 1'b1;
                  div_num   = NUM_W'({isum_in, {FRAC_W{1'b0}}});
                  div_den   = DEN_W'(ties_in);
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               est_in   = (div_quo[NUM_W-1:EST_W] != '0) ? {EST_W{1'b1}} : div_quo[EST_W-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_load   = 1'b1;
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         mode_ff    <= MODE_MEAN;
         issue_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         issue_ff   <= issue_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_wdata;
         end
      end
      row_ff    <= row_in;
      col_ff    <= col_in;
      col_ok_ff <= col_ok_in;
      scan_ff   <= scan_in;
      rd_idx_ff <= rd_idx_in;
      total_ff  <= total_in;
      wsum_ff   <= wsum_in;
      best_ff   <= best_in;
      isum_ff   <= isum_in;
      ties_ff   <= ties_in;
      est_ff    <= est_in;
      if (rsp_load) begin
         rsp_est_ff   <= est_ff;
         rsp_empty_ff <= (total_ff == '0);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'd0, rsp_empty_ff, rsp_est_ff};

   a_store_write_owner: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_FILL_WR))
      else $error("count store written outside clear or fill");

   a_div_nonzero_den: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (div_den != '0))
      else $error("divider started with zero divisor");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider result arrived outside divide state");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_vld_ff || rsp_tready))
      else $error("result register overwritten while word pending");

   a_fill_read_then_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL_RD) |=> (state_ff == ST_FILL_WR))
      else $error("fill read not followed by write back");

endmodule

### tb/sv/pulse_height_lut_charge_estimator_core_test.sv
// Self-checking testbench for the pulse-height charge estimator core, with its own predictor.
module pulse_height_lut_charge_estimator_core_test
   import phle_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 600;
   localparam int LONG_HOLD     = 3000;

   typedef struct packed {
      logic               kind;
      logic [FIELD_W-1:0] charge_index;
      logic [FIELD_W-1:0] adc_code;
   } req_word_type;

   typedef struct packed {
      logic             column_empty;
      logic [EST_W-1:0] charge_estimate;
   } estimate_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] charge_index, [15:8] adc_code
   logic        req_tuser  = 1'b0; // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] charge_estimate, [16] column_empty, [23:17] zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_wdata  = 1'b0;

   // predictor state
   logic [CNT_W-1:0] cal_counts [0:2**ADDR_W-1];
   logic             estimate_mode_q = MODE_MEAN;

   req_word_type pending_words[$];
   estimate_type expected_estimates[$];

   int   mismatches  = 0;
   int   cycle_count = 0;
   bit   req_taken   = 1'b0;
   bit   hold_rsp    = 1'b0;

   pulse_height_lut_charge_estimator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   function automatic estimate_type estimate_charge(input logic [FIELD_W-1:0] adc);
      logic [CNT_W-1:0]  c;
      logic [CNT_W-1:0]  peak;
      logic [TOT_W-1:0]  total;
      logic [WSUM_W-1:0] weighted;
      logic [ISUM_W-1:0] tie_sum;
      logic [TIE_W-1:0]  ties;
      logic [47:0]       num;
      logic [47:0]       den;
      logic [47:0]       q;
      estimate_type      r;
      int                i;
      total    = '0;
      weighted = '0;
      peak     = '0;
      tie_sum  = '0;
      ties     = '0;
      for (i = 0; i < BINS; i++) begin
         c = cal_counts[{IDX_W'(i), adc}];
         total    = total + TOT_W'(c);
         weighted = weighted + WSUM_W'(i) * WSUM_W'(c);
         // charge 0 never takes part in the peak search
         if (i >= 1 && c > peak) peak = c;
      end
      if (estimate_mode_q == MODE_MEAN) begin
         num = 48'(weighted) << FRAC_W;
         den = 48'(total);
      end else begin
         for (i = 1; i < BINS; i++) begin
            if (cal_counts[{IDX_W'(i), adc}] == peak) begin
               tie_sum = tie_sum + ISUM_W'(i);
               ties    = ties + 1'b1;
            end
         end
         num = 48'(tie_sum) << FRAC_W;
         den = 48'(ties);
      end
      q = (den == 0) ? 48'd0 : num / den;
      r.charge_estimate = (q > 48'hFFFF) ? '1 : q[EST_W-1:0];
      r.column_empty    = (total == 0);
      return r;
   endfunction

   function automatic void queue_fill(input logic [7:0] charge, input logic [7:0] adc);
      req_word_type w;
      w.kind         = KIND_FILL;
      w.charge_index = charge;
      w.adc_code     = adc;
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic void queue_query(input logic [7:0] adc);
      req_word_type w;
      w.kind         = KIND_QUERY;
      w.charge_index = 8'($urandom);   // ignored by a query
      w.adc_code     = adc;
      pending_words.insert(pending_words.size(), w);
   endfunction

   // Mostly column build-ups followed by a query of that column, plus stray words.
   function automatic void queue_random_mix(input int n_words, input bit with_wrap);
      logic [7:0] hot [4];
      logic [7:0] a;
      logic [7:0] c;
      logic [7:0] base;
      int         added;
      int         sel;
      int         nf;
      int         spread;
      int         j;
      added  = 0;
      hot[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      for (j = 1; j < 4; j++) hot[j] = 8'($urandom);
      if (with_wrap) begin
         // push one cell past 255 counts
         c  = 8'($urandom);
         a  = hot[$urandom_range(0, 3)];
         nf = 256 + $urandom_range(1, 4);
         for (j = 0; j < nf; j++) queue_fill(c, a);
         queue_query(a);
         added = nf + 1;
      end
      while (added < n_words) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            a      = hot[$urandom_range(0, 3)];
            nf     = $urandom_range(1, 10);
            spread = $urandom_range(0, 2);
            base   = 8'($urandom);
            for (j = 0; j < nf; j++) begin
               case (spread)
                  0: c = 8'($urandom);
                  1: c = base + 8'($urandom_range(0, 2));   // few rows: peaks and ties
                  default: c = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
               endcase
               queue_fill(c, a);
            end
            queue_query(a);
            added += nf + 1;
         end else if (sel < 85) begin
            queue_fill(8'($urandom), 8'($urandom));
            added++;
         end else if (sel < 95) begin
            queue_query(8'($urandom));
            added++;
         end else begin
            queue_query(hot[$urandom_range(0, 3)]);
            added++;
         end
      end
   endfunction

   task automatic drain_block();
      while (pending_words.size() != 0 || expected_estimates.size() != 0)
         @(negedge clock);
      // a fill may still be writing back
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_estimate_mode(input logic mode);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      estimate_mode_q = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      int  gap_left;
      int  req_steady;
      logic v;
      v = req_tvalid;
      if (req_taken) begin
         v = 1'b0;
         req_taken = 1'b0;
         if (req_steady > 0) req_steady--;
         else if ($urandom_range(0, 99) < 3) req_steady = $urandom_range(20, 80);
         else gap_left = idle_length();
      end
      if (!v && !reset) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_words.size() != 0) begin
            req_tdata <= {pending_words[0].adc_code, pending_words[0].charge_index};
            req_tuser <= pending_words[0].kind;
            v = 1'b1;
         end
      end
      req_tvalid <= v;
   end

   // accepted request words update the predictor
   always @(posedge clock) begin : track_requests
      logic [FIELD_W-1:0] charge;
      logic [FIELD_W-1:0] adc;
      if (req_tvalid && req_tready) begin
         charge = req_tdata[7:0];
         adc    = req_tdata[15:8];
         if (req_tuser == KIND_FILL)
            cal_counts[{charge, adc}] = cal_counts[{charge, adc}] + 1'b1;
         else
            expected_estimates.insert(expected_estimates.size(), estimate_charge(adc));
         void'(pending_words.pop_front());
         req_taken = 1'b1;
      end
   end

   // result back-pressure
   always @(negedge clock) begin : drive_rsp_ready
      int   hold_left;
      int   stall_left;
      int   rsp_steady;
      logic r;
      if (hold_rsp) begin
         hold_left = LONG_HOLD;
         hold_rsp  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         r = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         r = 1'b0;
      end else begin
         r = 1'b1;
         if (rsp_steady > 0) rsp_steady--;
         else if ($urandom_range(0, 99) < 4) rsp_steady = $urandom_range(20, 80);
         else if ($urandom_range(0, 99) < 20) stall_left = idle_length();
      end
      rsp_tready <= r;
   end

   // result checker
   always @(posedge clock) begin : check_results
      estimate_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_estimates.size() == 0) begin
            $error("unexpected result word: rsp_tdata=%h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_estimates.pop_front();
            if (rsp_tdata[15:0] !== want.charge_estimate) begin
               $error("charge_estimate: expected %h, actual %h",
                      want.charge_estimate, rsp_tdata[15:0]);
               mismatches++;
            end
            if (rsp_tdata[16] !== want.column_empty) begin
               $error("column_empty: expected %b, actual %b", want.column_empty, rsp_tdata[16]);
               mismatches++;
            end
            if (rsp_tdata[23:17] !== 7'd0) begin
               $error("rsp_tdata padding: expected %h, actual %h", 7'd0, rsp_tdata[23:17]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : run_test
      int k;
      for (k = 0; k < 2**ADDR_W; k++) cal_counts[k] = '0;

      // mean mode out of reset: empty columns, charge-0 counts, extremes
      queue_query(8'h00);
      queue_query(8'hFF);
      queue_fill(8'h00, 8'd10);
      queue_query(8'd10);
      queue_fill(8'hFF, 8'd10);
      queue_fill(8'hFF, 8'd10);
      queue_fill(8'h01, 8'd10);
      queue_query(8'd10);
      queue_fill(8'hFF, 8'hFF);
      queue_query(8'hFF);

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      drain_block();

      // mode search: empty column, only charge 0, a tie, single peaks
      write_estimate_mode(MODE_PEAK);
      queue_query(8'h00);
      queue_fill(8'h00, 8'd20);
      queue_query(8'd20);
      queue_fill(8'd3, 8'd30);
      queue_fill(8'd7, 8'd30);
      queue_query(8'd30);
      queue_query(8'd10);
      queue_query(8'hFF);
      drain_block();

      write_estimate_mode(MODE_MEAN);
      queue_query(8'd20);
      queue_query(8'd30);
      drain_block();

      write_estimate_mode(MODE_PEAK);
      queue_random_mix(230, 1'b1);
      drain_block();

      // receiver holds off while queries keep coming
      write_estimate_mode(MODE_MEAN);
      queue_random_mix(230, 1'b0);
      @(posedge clock);
      hold_rsp = 1'b1;
      drain_block();

      write_estimate_mode(MODE_PEAK);
      queue_random_mix(230, 1'b0);
      drain_block();

      write_estimate_mode(MODE_MEAN);
      queue_random_mix(230, 1'b0);
      drain_block();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_estimates.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/phle_pkg.sv
rtl/phle_divider.sv
rtl/pulse_height_lut_charge_estimator_core.sv
tb/sv/pulse_height_lut_charge_estimator_core_test.sv
